// ===== sv/bfa_pkg.sv =====
// Shared types and constants for the bitmap frame allocator.
package bfa_pkg;

	localparam int WORD_BITS = 32;
	localparam int BIT_IDX_W = 5;

	typedef enum logic [1:0] {
		OP_ALLOC      = 2'd0,
		OP_FREE       = 2'd1,
		OP_RANGE_FREE = 2'd2,
		OP_RANGE_USED = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_OK  = 2'd0,
		ST_OOM = 2'd1,
		ST_OOB = 2'd2
	} st_code_t;

	typedef struct packed {
		logic clr;
		logic load;
		logic rd;
		logic mod;
		logic next_row;
	} dp_cmd_t;

	typedef struct packed {
		logic clr_done;
		logic skip;
		logic finish;
	} dp_stat_t;

endpackage

// ===== sv/bfa_ctrl.sv =====
// Controller state machine: clearing pass, operation sequencing, beat strobes.
module bfa_ctrl
	import bfa_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     start,
	input  dp_stat_t stat,
	output dp_cmd_t  cmd,
	output logic     busy,
	output logic     done
);

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_EVAL,
		S_RD,
		S_MOD
	} state_t;

	state_t state_q;
	logic   busy_q;
	logic   done_q;

	always_comb begin
		cmd          = '0;
		cmd.clr      = (state_q == S_CLEAR);
		cmd.load     = (state_q == S_IDLE) && start;
		cmd.rd       = (state_q == S_RD);
		cmd.mod      = (state_q == S_MOD);
		cmd.next_row = (state_q == S_MOD) && !stat.finish;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			busy_q  <= 1'b1;
			done_q  <= 1'b0;
		end else begin
			done_q <= ((state_q == S_EVAL) && stat.skip) ||
				((state_q == S_MOD) && stat.finish);
			unique case (state_q)
				S_CLEAR: begin
					if (stat.clr_done) begin
						state_q <= S_IDLE;
						busy_q  <= 1'b0;
					end
				end
				S_IDLE: begin
					if (start) begin
						state_q <= S_EVAL;
						busy_q  <= 1'b1;
					end
				end
				S_EVAL: begin
					if (stat.skip) begin
						state_q <= S_IDLE;
						busy_q  <= 1'b0;
					end else begin
						state_q <= S_RD;
					end
				end
				S_RD: begin
					state_q <= S_MOD;
				end
				S_MOD: begin
					if (stat.finish) begin
						state_q <= S_IDLE;
						busy_q  <= 1'b0;
					end else begin
						state_q <= S_RD;
					end
				end
				default: begin
					state_q <= S_CLEAR;
					busy_q  <= 1'b1;
				end
			endcase
		end
	end

	assign busy = busy_q;
	assign done = done_q;

endmodule

// ===== sv/bfa_dp.sv =====
// Datapath: bitmap memory, row walker, bit masks, limit register and results.
module bfa_dp
	import bfa_pkg::*;
#(
	parameter int NUM_FRAMES = 32768,
	parameter int PAGE_BYTES = 4096
) (
	input  logic        clk,
	input  logic        arst_n,
	input  dp_cmd_t     cmd,
	output dp_stat_t    stat,
	input  logic [1:0]  op,
	input  logic [31:0] phys_addr,
	input  logic [19:0] range_start,
	input  logic [19:0] range_end,
	input  logic        frame_limit_we,
	input  logic [15:0] frame_limit_wdata,
	output logic [1:0]  status,
	output logic [31:0] frame_addr
);

	localparam int ROWS       = (NUM_FRAMES + WORD_BITS - 1) / WORD_BITS;
	localparam int ROW_W      = (ROWS > 1) ? $clog2(ROWS) : 1;
	localparam int FIDX_W     = ROW_W + BIT_IDX_W;
	localparam int PAGE_SHIFT = $clog2(PAGE_BYTES);

	logic [WORD_BITS-1:0] mem [ROWS];

	logic [15:0]          frame_limit_q;
	logic [ROW_W-1:0]     row_q;
	logic [FIDX_W-1:0]    first_q;
	logic [FIDX_W-1:0]    last_q;
	op_t                  op_q;
	logic                 set_q;
	logic                 skip_q;
	logic [WORD_BITS-1:0] rdata_q;
	logic [1:0]           status_q;
	logic [31:0]          faddr_q;

	logic [31:0]          lim32;
	logic [31:0]          fr32;
	logic [31:0]          rs32;
	logic [31:0]          last_r32;
	logic [31:0]          ld_first32;
	logic [31:0]          ld_last32;
	logic                 ld_skip;
	logic                 ld_set;
	st_code_t             ld_status;

	logic [ROW_W-1:0]     first_row;
	logic [ROW_W-1:0]     last_row;
	logic [BIT_IDX_W-1:0] first_bit;
	logic [BIT_IDX_W-1:0] last_bit;
	logic [WORD_BITS-1:0] mask;
	logic [WORD_BITS-1:0] cand;
	logic [WORD_BITS-1:0] lowbit;
	logic [BIT_IDX_W-1:0] low_idx;
	logic                 found;
	logic                 at_last;
	logic                 is_alloc;
	logic                 we;
	logic [WORD_BITS-1:0] wdata;

	always_comb begin
		lim32 = ({16'b0, frame_limit_q} > 32'(NUM_FRAMES)) ?
			32'(NUM_FRAMES) : {16'b0, frame_limit_q};
		fr32 = phys_addr >> PAGE_SHIFT;
		rs32 = {12'b0, range_start};
		last_r32 = ({12'b0, range_end} > 32'(NUM_FRAMES - 1)) ?
			32'(NUM_FRAMES - 1) : {12'b0, range_end};
		ld_first32 = '0;
		ld_last32  = '0;
		ld_skip    = 1'b0;
		ld_set     = 1'b0;
		ld_status  = ST_OK;
		unique case (op_t'(op))
			OP_ALLOC: begin
				ld_last32 = lim32 - 32'd1;
				ld_skip   = (lim32 == 32'd0);
				ld_status = ld_skip ? ST_OOM : ST_OK;
				ld_set    = 1'b1;
			end
			OP_FREE: begin
				ld_first32 = fr32;
				ld_last32  = fr32;
				ld_skip    = (fr32 >= 32'(NUM_FRAMES));
				ld_status  = ld_skip ? ST_OOB : ST_OK;
			end
			OP_RANGE_FREE, OP_RANGE_USED: begin
				ld_first32 = rs32;
				ld_last32  = last_r32;
				ld_skip    = (rs32 > last_r32);
				ld_set     = (op_t'(op) == OP_RANGE_USED);
			end
			default: begin
				ld_skip = 1'b1;
			end
		endcase
	end

	always_comb begin
		first_row = first_q[FIDX_W-1:BIT_IDX_W];
		last_row  = last_q[FIDX_W-1:BIT_IDX_W];
		first_bit = first_q[BIT_IDX_W-1:0];
		last_bit  = last_q[BIT_IDX_W-1:0];
		for (int b = 0; b < WORD_BITS; b++) begin
			mask[b] = ((row_q != first_row) || (BIT_IDX_W'(b) >= first_bit)) &&
				((row_q != last_row) || (BIT_IDX_W'(b) <= last_bit));
		end
		cand    = mask & ~rdata_q;
		found   = |cand;
		lowbit  = cand & (~cand + WORD_BITS'(1));
		low_idx = '0;
		for (int b = WORD_BITS - 1; b >= 0; b--) begin
			if (cand[b]) begin
				low_idx = BIT_IDX_W'(b);
			end
		end
		at_last  = (row_q == last_row);
		is_alloc = (op_q == OP_ALLOC);
		if (cmd.clr) begin
			wdata = '1;
		end else if (is_alloc) begin
			wdata = rdata_q | lowbit;
		end else if (set_q) begin
			wdata = rdata_q | mask;
		end else begin
			wdata = rdata_q & ~mask;
		end
		we = cmd.clr || (cmd.mod && (!is_alloc || found));
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[row_q] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.rd) begin
			rdata_q <= mem[row_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_limit_q <= '0;
			row_q         <= '0;
			skip_q        <= 1'b0;
			op_q          <= OP_ALLOC;
		end else begin
			if (frame_limit_we) begin
				frame_limit_q <= frame_limit_wdata;
			end
			if (cmd.load) begin
				row_q  <= ld_first32[FIDX_W-1:BIT_IDX_W];
				skip_q <= ld_skip;
				op_q   <= op_t'(op);
			end else if (cmd.clr || cmd.next_row) begin
				row_q <= row_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			first_q  <= ld_first32[FIDX_W-1:0];
			last_q   <= ld_last32[FIDX_W-1:0];
			set_q    <= ld_set;
			status_q <= ld_status;
			faddr_q  <= '0;
		end else if (cmd.mod && is_alloc) begin
			if (found) begin
				faddr_q <= 32'({row_q, low_idx}) << PAGE_SHIFT;
			end else if (at_last) begin
				status_q <= ST_OOM;
			end
		end
	end

	always_comb begin
		stat          = '0;
		stat.clr_done = (row_q == ROW_W'(ROWS - 1));
		stat.skip     = skip_q;
		stat.finish   = at_last || (is_alloc && found);
	end

	assign status     = status_q;
	assign frame_addr = faddr_q;

endmodule

// ===== sv/bitmap_frame_allocator_core.sv =====
// Top level of the bitmap page-frame allocator.
// Allocate: each 32-frame row scanned is read, then modified and written back.
// Free: one row read and written back; mark range: the same for each row touched.
// done pulses in the cycle after the last modify state (evaluate state if rejected).
// One beat in flight, no result stall. After reset busy stays high while the clearing pass
// marks every frame used row by row (1024 rows by default); frame_limit resets to 0.
module bitmap_frame_allocator_core
	import bfa_pkg::*;
#(
	parameter int NUM_FRAMES = 32768,
	parameter int PAGE_BYTES = 4096
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  op,
	input  logic [31:0] phys_addr,
	input  logic [19:0] range_start,
	input  logic [19:0] range_end,
	output logic        done,
	output logic [1:0]  status,
	output logic [31:0] frame_addr,
	input  logic        frame_limit_we,
	input  logic [15:0] frame_limit_wdata
);

	dp_cmd_t  cmd;
	dp_stat_t stat;

	bfa_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.stat   (stat),
		.cmd    (cmd),
		.busy   (busy),
		.done   (done)
	);

	bfa_dp #(
		.NUM_FRAMES (NUM_FRAMES),
		.PAGE_BYTES (PAGE_BYTES)
	) u_dp (
		.clk               (clk),
		.arst_n            (arst_n),
		.cmd               (cmd),
		.stat              (stat),
		.op                (op),
		.phys_addr         (phys_addr),
		.range_start       (range_start),
		.range_end         (range_end),
		.frame_limit_we    (frame_limit_we),
		.frame_limit_wdata (frame_limit_wdata),
		.status            (status),
		.frame_addr        (frame_addr)
	);

endmodule

// ===== sv/bfa_checker.sv =====
// Port-level checks for the allocator core, bound to the top level.
module bfa_checker
	import bfa_pkg::*;
(
	input logic        clk,
	input logic        arst_n,
	input logic        start,
	input logic        busy,
	input logic        done,
	input logic [1:0]  status,
	input logic [31:0] frame_addr
);

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result beat while busy");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("busy not raised after accepted beat");

	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe longer than one cycle");

	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		(!busy && !start) |=> !done)
		else $error("result beat without accepted beat");

	a_oom_addr: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (status == ST_OOM || status == ST_OOB)) |-> (frame_addr == 32'd0))
		else $error("non-zero address on failed beat");

endmodule

bind bitmap_frame_allocator_core bfa_checker u_bfa_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.start      (start),
	.busy       (busy),
	.done       (done),
	.status     (status),
	.frame_addr (frame_addr)
);

// ===== tb/testbench.sv =====
// Testbench for the bitmap frame allocator core: a directed table, then randomised limit phases.
`timescale 1ns / 1ps

module testbench;
	import bfa_pkg::*;

	localparam int NUM_FRAMES   = 32768;
	localparam int PAGE_BYTES   = 4096;
	localparam int RANDOM_ITEMS = 1100;
	localparam int QUIET_FROM   = 950;
	localparam int LIMIT_CYCLES = 10_000_000;
	localparam int SCRIPT_LEN   = 27;

	typedef struct packed {
		st_code_t    st;
		logic [31:0] fa;
	} frame_result_t;

	typedef struct packed {
		logic        set_lim;
		logic [15:0] lim;
		op_t         op;
		logic [31:0] addr;
		logic [19:0] rs;
		logic [19:0] re;
		logic        typed;
		st_code_t    st;
		logic [31:0] fa;
	} step_t;

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	logic [1:0]  op;
	logic [31:0] phys_addr;
	logic [19:0] range_start;
	logic [19:0] range_end;
	logic        done;
	logic [1:0]  status;
	logic [31:0] frame_addr;
	logic        frame_limit_we;
	logic [15:0] frame_limit_wdata;

	bit            frames_used [NUM_FRAMES];
	logic [15:0]   alloc_limit;
	frame_result_t pending_results [$];
	int            mismatches = 0;
	int            cycle_count = 0;
	bit            idling_on;

	step_t script [SCRIPT_LEN] = '{
		'{1'b0, 16'd0, OP_ALLOC, 32'h0, 20'h0, 20'h0, 1'b1, ST_OOM, 32'h0},
		'{1'b1, 16'd16, OP_ALLOC, 32'h0, 20'h0, 20'h0, 1'b0, ST_OK, 32'h0},
		'{1'b0, 16'd0, OP_ALLOC, 32'hFFFFFFFF, 20'hFFFFF, 20'hFFFFF, 1'b1, ST_OOM, 32'h0},
		'{1'b0, 16'd0, OP_FREE, 32'h0, 20'h0, 20'h0, 1'b1, ST_OK, 32'h0},
		'{1'b0, 16'd0, OP_ALLOC, 32'h0, 20'h0, 20'h0, 1'b1, ST_OK, 32'h0},
		'{1'b0, 16'd0, OP_RANGE_FREE, 32'h0, 20'h0, 20'hFFFFF, 1'b1, ST_OK, 32'h0},
		'{1'b0, 16'd0, OP_ALLOC, 32'h0, 20'h0, 20'h0, 1'b0, ST_OK, 32'h0},
		'{1'b0, 16'd0, OP_ALLOC, 32'h0, 20'h0, 20'h0, 1'b0, ST_OK, 32'h0},
		'{1'b0, 16'd0, OP_FREE, 32'hFFFFFFFF, 20'h0, 20'h0, 1'b1, ST_OOB, 32'h0},
		'{1'b0, 16'd0, OP_FREE, 32'h07FFFFFF, 20'h0, 20'h0, 1'b1, ST_OK, 32'h0},
		'{1'b0, 16'd0, OP_RANGE_USED, 32'h0, 20'd5, 20'd3, 1'b1, ST_OK, 32'h0},
		'{1'b0, 16'd0, OP_RANGE_USED, 32'h0, 20'hFFFFF, 20'hFFFFF, 1'b1, ST_OK, 32'h0},
		'{1'b0, 16'd0, OP_RANGE_USED, 32'h0, 20'h0, 20'hFFFFF, 1'b1, ST_OK, 32'h0},
		'{1'b1, 16'hFFFF, OP_ALLOC, 32'h0, 20'h0, 20'h0, 1'b0, ST_OK, 32'h0},
		'{1'b0, 16'd0, OP_ALLOC, 32'h0, 20'h0, 20'h0, 1'b1, ST_OOM, 32'h0},
		'{1'b0, 16'd0, OP_FREE, 32'h07FFF000, 20'h0, 20'h0, 1'b1, ST_OK, 32'h0},
		'{1'b0, 16'd0, OP_ALLOC, 32'h0, 20'h0, 20'h0, 1'b1, ST_OK, 32'h07FFF000},
		'{1'b0, 16'd0, OP_ALLOC, 32'h0, 20'h0, 20'h0, 1'b1, ST_OOM, 32'h0},
		'{1'b0, 16'd0, OP_RANGE_FREE, 32'h0, 20'd32760, 20'd32767, 1'b1, ST_OK, 32'h0},
		'{1'b1, 16'd32768, OP_ALLOC, 32'h0, 20'h0, 20'h0, 1'b0, ST_OK, 32'h0},
		'{1'b0, 16'd0, OP_ALLOC, 32'h0, 20'h0, 20'h0, 1'b0, ST_OK, 32'h0},
		'{1'b1, 16'd0, OP_ALLOC, 32'h0, 20'h0, 20'h0, 1'b0, ST_OK, 32'h0},
		'{1'b0, 16'd0, OP_ALLOC, 32'h0, 20'h0, 20'h0, 1'b1, ST_OOM, 32'h0},
		'{1'b0, 16'd0, OP_FREE, 32'h08000000, 20'h0, 20'h0, 1'b1, ST_OOB, 32'h0},
		'{1'b0, 16'd0, OP_FREE, 32'h00000FFF, 20'h0, 20'h0, 1'b1, ST_OK, 32'h0},
		'{1'b1, 16'd1, OP_ALLOC, 32'h0, 20'h0, 20'h0, 1'b0, ST_OK, 32'h0},
		'{1'b0, 16'd0, OP_ALLOC, 32'h0, 20'h0, 20'h0, 1'b1, ST_OK, 32'h0}
	};

	bitmap_frame_allocator_core #(
		.NUM_FRAMES(NUM_FRAMES),
		.PAGE_BYTES(PAGE_BYTES)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.op(op),
		.phys_addr(phys_addr),
		.range_start(range_start),
		.range_end(range_end),
		.done(done),
		.status(status),
		.frame_addr(frame_addr),
		.frame_limit_we(frame_limit_we),
		.frame_limit_wdata(frame_limit_wdata)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	task automatic predict_frame_op(input op_t o, input logic [31:0] a, input logic [19:0] s,
			input logic [19:0] e, output st_code_t st, output logic [31:0] fa);
		int unsigned lim;
		int unsigned f;
		int unsigned last;
		st = ST_OK;
		fa = '0;
		case (o)
			OP_ALLOC: begin
				lim = (alloc_limit > NUM_FRAMES) ? NUM_FRAMES : alloc_limit;
				st = ST_OOM;
				for (f = 0; f < lim; f++) begin
					if (!frames_used[f]) begin
						frames_used[f] = 1'b1;
						fa = 32'(longint'(f) * PAGE_BYTES);
						st = ST_OK;
						break;
					end
				end
			end
			OP_FREE: begin
				f = a / 32'(PAGE_BYTES);
				if (f < NUM_FRAMES)
					frames_used[f] = 1'b0;
				else
					st = ST_OOB;
			end
			default: begin
				last = (e > NUM_FRAMES - 1) ? NUM_FRAMES - 1 : e;
				for (f = 32'(s); f <= last; f++)
					frames_used[f] = (o == OP_RANGE_USED);
			end
		endcase
	endtask

	task automatic issue(input op_t o, input logic [31:0] a, input logic [19:0] s,
			input logic [19:0] e, input bit typed, input st_code_t tst, input logic [31:0] tfa);
		frame_result_t r;
		int gap;
		gap = (idling_on && $urandom_range(0, 3) == 0) ? $urandom_range(1, 17) : 0;
		@(negedge clk);
		if (gap != 0) begin
			start <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		start <= 1'b1;
		op <= o;
		phys_addr <= a;
		range_start <= s;
		range_end <= e;
		@(posedge clk);
		while (busy) @(posedge clk);
		predict_frame_op(o, a, s, e, r.st, r.fa);
		if (typed) begin
			r.st = tst;
			r.fa = tfa;
		end
		pending_results.push_back(r);
	endtask

	task automatic write_limit(input logic [15:0] v);
		@(negedge clk);
		start <= 1'b0;
		while (pending_results.size() != 0 || busy) @(posedge clk);
		@(negedge clk);
		frame_limit_we <= 1'b1;
		frame_limit_wdata <= v;
		@(negedge clk);
		frame_limit_we <= 1'b0;
		alloc_limit = v;
	endtask

	always @(posedge clk) begin : check_beat
		frame_result_t want;
		if (arst_n && done) begin
			if (pending_results.size() == 0) begin
				$display("%0t unexpected beat: status %0d frame_addr %h", $time, status, frame_addr);
				mismatches++;
			end else begin
				want = pending_results.pop_front();
				if (status !== want.st) begin
					$display("%0t status expected %0d actual %0d", $time, want.st, status);
					mismatches++;
				end
				if (frame_addr !== want.fa) begin
					$display("%0t frame_addr expected %h actual %h", $time, want.fa, frame_addr);
					mismatches++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == LIMIT_CYCLES) begin
			$display("FAILURE");
			$finish;
		end
	end

	initial begin : stimulus
		int sent;
		int n;
		int sel;
		int unsigned lim_eff;
		int unsigned span;
		int unsigned frame;
		logic [15:0] lim;
		op_t o;
		logic [31:0] a;
		logic [19:0] s;
		logic [19:0] e;
		arst_n = 1'b0;
		start = 1'b0;
		op = OP_ALLOC;
		phys_addr = '0;
		range_start = '0;
		range_end = '0;
		frame_limit_we = 1'b0;
		frame_limit_wdata = '0;
		alloc_limit = '0;
		idling_on = 1'b1;
		foreach (frames_used[i])
			frames_used[i] = 1'b1;
		repeat (4) @(negedge clk);
		arst_n <= 1'b1;

		foreach (script[i]) begin
			if (script[i].set_lim)
				write_limit(script[i].lim);
			else
				issue(script[i].op, script[i].addr, script[i].rs, script[i].re,
					script[i].typed, script[i].st, script[i].fa);
		end

		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			sel = $urandom_range(0, 99);
			if (sel < 65)
				lim = 16'($urandom_range(1, 512));
			else if (sel < 75)
				lim = 16'd0;
			else if (sel < 82)
				lim = 16'($urandom_range(513, 4096));
			else if (sel < 88)
				lim = 16'(NUM_FRAMES);
			else if (sel < 93)
				lim = 16'hFFFF;
			else
				lim = 16'($urandom_range(0, 65535));
			write_limit(lim);
			lim_eff = (lim > NUM_FRAMES) ? NUM_FRAMES : lim;
			span = (lim_eff == 0) ? 64 : lim_eff + 32;
			if (span > NUM_FRAMES)
				span = NUM_FRAMES;
			n = $urandom_range(20, 60);
			repeat (n) begin
				idling_on = (sent < QUIET_FROM) && ($urandom_range(0, 3) != 0);
				sel = $urandom_range(0, 99);
				a = $urandom();
				s = 20'($urandom_range(0, 20'hFFFFF));
				e = 20'($urandom_range(0, 20'hFFFFF));
				if (sel < 40) begin
					o = OP_ALLOC;
				end else if (sel < 65) begin
					o = OP_FREE;
					frame = $urandom_range(0, span - 1);
					a = frame * PAGE_BYTES + $urandom_range(0, PAGE_BYTES - 1);
				end else if (sel < 90) begin
					o = (sel < 78) ? OP_RANGE_FREE : OP_RANGE_USED;
					s = 20'($urandom_range(0, span - 1));
					e = 20'(s + $urandom_range(0, 40));
				end else if (sel < 95) begin
					o = OP_FREE;
				end else begin
					o = $urandom_range(0, 1) ? OP_RANGE_FREE : OP_RANGE_USED;
				end
				issue(o, a, s, e, 1'b0, ST_OK, 32'h0);
				sent++;
			end
		end

		@(negedge clk);
		start <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (16) @(posedge clk);
		if (mismatches == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
